/* hw/rtl/cll_pkg.sv */
// Package for the code lock: payload words, mode and event codes,
// configuration register indexes and reset values.
// No dependencies; every other file of the lock imports it.
`timescale 1ns / 1ps
`default_nettype none

package cll_pkg;

  // Entry buffer depth and derived widths
  localparam int MAX_LEN   = 8;
  localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int COUNT_W   = $clog2(MAX_LEN + 1);

  // Blink half period in milliseconds
  localparam int BLINK_MS  = 200;
  localparam int BLINK_W   = $clog2(BLINK_MS);

  // Elapsed-time counter: wide enough to pass the largest duration
  localparam int TICKS_W   = 20;
  localparam int ELAPSED_W = TICKS_W + 1;

  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Configuration reset values
  localparam logic [3:0]         RST_PASSWORD_LENGTH = 4'd4;
  localparam logic [63:0]        RST_PASSWORD_CHARS  = 64'h0000_0000_3433_3231;
  localparam logic [3:0]         RST_MAX_ATTEMPTS    = 4'd3;
  localparam logic [TICKS_W-1:0] RST_UNLOCK_TICKS    = 20'd5000;
  localparam logic [TICKS_W-1:0] RST_BLOCK_TICKS     = 20'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PASSWORD_LENGTH = 3'd0,
    CFG_PASSWORD_CHARS  = 3'd1,
    CFG_MAX_ATTEMPTS    = 3'd2,
    CFG_UNLOCK_TICKS    = 3'd3,
    CFG_BLOCK_TICKS     = 3'd4
  } cfg_index_t;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_LOCKED  = 2'd0,
    MODE_OPEN    = 2'd1,
    MODE_BLOCKED = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    EV_NONE            = 4'd0,
    EV_ECHO            = 4'd1,
    EV_GRANTED         = 4'd2,
    EV_DENIED          = 4'd3,
    EV_LOCKOUT         = 4'd4,
    EV_IGNORED_BLOCKED = 4'd5,
    EV_IGNORED_OPEN    = 4'd6,
    EV_RELOCKED        = 4'd7,
    EV_BLOCK_ENDED     = 4'd8
  } event_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic       lamp;
    logic [1:0] mode;
    logic [3:0] attempts_left;
    logic [3:0] event_res;
  } out_word_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
  } cfg_write_t;

endpackage

`default_nettype wire

/* hw/rtl/cll_core.sv */
// Lock state, configuration registers and the one-pass update per word.
// Depends on cll_pkg. The result is combinational; the top level registers it.
`timescale 1ns / 1ps
`default_nettype none

module cll_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  cll_pkg::in_word_t   in_word,
  input  cll_pkg::cfg_write_t cfg_wr,
  output cll_pkg::out_word_t  result
);
  import cll_pkg::*;

  // Configuration registers
  logic [3:0]         password_length;
  logic [63:0]        password_chars;
  logic [3:0]         max_attempts;
  logic [TICKS_W-1:0] unlock_ticks;
  logic [TICKS_W-1:0] block_ticks;

  // Lock state
  mode_t                lock_mode, lock_mode_next;
  logic [7:0]           entry_buffer [MAX_LEN];
  logic [COUNT_W-1:0]   entry_count, entry_count_next;
  logic                 entry_overflow, entry_overflow_next;
  logic [3:0]           failed_count, failed_count_next;
  logic [31:0]          now_ms, now_ms_next;
  logic [BLINK_W-1:0]   blink_ms, blink_ms_next;
  logic                 blink_phase, blink_phase_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;

  logic                 buf_we;
  logic [MAX_LEN-1:0]   byte_ok;
  logic                 entry_match;
  logic                 is_enter;
  logic [3:0]           failed_sat;
  logic [ELAPSED_W-1:0] elapsed_inc;
  event_t               ev;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      password_length <= RST_PASSWORD_LENGTH;
      password_chars  <= RST_PASSWORD_CHARS;
      max_attempts    <= RST_MAX_ATTEMPTS;
      unlock_ticks    <= RST_UNLOCK_TICKS;
      block_ticks     <= RST_BLOCK_TICKS;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        CFG_PASSWORD_LENGTH: password_length <= cfg_wr.data[3:0];
        CFG_PASSWORD_CHARS:  password_chars  <= cfg_wr.data;
        CFG_MAX_ATTEMPTS:    max_attempts    <= cfg_wr.data[3:0];
        CFG_UNLOCK_TICKS:    unlock_ticks    <= cfg_wr.data[TICKS_W-1:0];
        CFG_BLOCK_TICKS:     block_ticks     <= cfg_wr.data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Compare entry against password, one lane per buffered byte
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      byte_ok[i] = (COUNT_W'(i) >= entry_count) ||
                   (entry_buffer[i] == password_chars[8*i +: 8]);
    end
  end

  assign entry_match = !entry_overflow && (password_length != 4'd0) &&
                       (password_length <= 4'(MAX_LEN)) &&
                       (COUNT_W'(password_length) == entry_count) && (&byte_ok);

  assign is_enter    = (in_word.char_code == CHAR_LF) || (in_word.char_code == CHAR_CR);
  assign failed_sat  = (failed_count == 4'hF) ? 4'hF : failed_count + 4'd1;
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + ELAPSED_W'(1);

  // Next state and event for the word at the input
  always_comb begin
    lock_mode_next      = lock_mode;
    entry_count_next    = entry_count;
    entry_overflow_next = entry_overflow;
    failed_count_next   = failed_count;
    now_ms_next         = now_ms;
    blink_ms_next       = blink_ms;
    blink_phase_next    = blink_phase;
    elapsed_next        = elapsed;
    buf_we              = 1'b0;
    ev                  = EV_NONE;

    if (in_word.opcode == OP_TICK) begin
      // Advance time; restart the blink phase where the millisecond count wraps
      now_ms_next = now_ms + 32'd1;
      if (&now_ms) begin
        blink_ms_next    = '0;
        blink_phase_next = 1'b0;
      end else if (blink_ms == BLINK_W'(BLINK_MS - 1)) begin
        blink_ms_next    = '0;
        blink_phase_next = !blink_phase;
      end else begin
        blink_ms_next    = blink_ms + BLINK_W'(1);
      end
      elapsed_next = elapsed_inc;
      if (lock_mode == MODE_OPEN) begin
        if (elapsed_inc >= {1'b0, unlock_ticks}) begin
          lock_mode_next = MODE_LOCKED;
          ev             = EV_RELOCKED;
        end
      end else if (lock_mode == MODE_BLOCKED) begin
        if (elapsed_inc >= {1'b0, block_ticks}) begin
          lock_mode_next    = MODE_LOCKED;
          failed_count_next = 4'd0;
          ev                = EV_BLOCK_ENDED;
        end
      end
    end else if (lock_mode == MODE_BLOCKED) begin
      ev = EV_IGNORED_BLOCKED;
    end else if (lock_mode == MODE_OPEN) begin
      ev = EV_IGNORED_OPEN;
    end else if (is_enter) begin
      // Judge a non-empty entry, then clear it
      if ((entry_count != '0) || entry_overflow) begin
        if (entry_match) begin
          lock_mode_next    = MODE_OPEN;
          failed_count_next = 4'd0;
          elapsed_next      = '0;
          ev                = EV_GRANTED;
        end else begin
          failed_count_next = failed_sat;
          if (failed_sat >= max_attempts) begin
            lock_mode_next = MODE_BLOCKED;
            elapsed_next   = '0;
            ev             = EV_LOCKOUT;
          end else begin
            ev = EV_DENIED;
          end
        end
        entry_count_next    = '0;
        entry_overflow_next = 1'b0;
      end
    end else begin
      // Buffer the character, or flag an overlong entry
      if (entry_count < COUNT_W'(MAX_LEN)) begin
        buf_we           = 1'b1;
        entry_count_next = entry_count + COUNT_W'(1);
      end else begin
        entry_overflow_next = 1'b1;
      end
      ev = EV_ECHO;
    end
  end

  // Result word, taken after the update
  always_comb begin
    result.mode          = lock_mode_next;
    result.event_res     = ev;
    result.attempts_left = (failed_count_next >= max_attempts) ? 4'd0
                           : max_attempts - failed_count_next;
    unique case (lock_mode_next)
      MODE_OPEN:    result.lamp = 1'b1;
      MODE_BLOCKED: result.lamp = blink_phase_next;
      default:      result.lamp = 1'b0;
    endcase
  end

  // Hold state; advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_mode      <= MODE_LOCKED;
      entry_count    <= '0;
      entry_overflow <= 1'b0;
      failed_count   <= 4'd0;
      now_ms         <= 32'd0;
      blink_ms       <= '0;
      blink_phase    <= 1'b0;
      elapsed        <= '0;
    end else if (accept) begin
      lock_mode      <= lock_mode_next;
      entry_count    <= entry_count_next;
      entry_overflow <= entry_overflow_next;
      failed_count   <= failed_count_next;
      now_ms         <= now_ms_next;
      blink_ms       <= blink_ms_next;
      blink_phase    <= blink_phase_next;
      elapsed        <= elapsed_next;
    end
  end

  // Entry buffer: written at the fill position, no reset
  always_ff @(posedge clk) begin
    if (accept && buf_we) begin
      entry_buffer[entry_count[IDX_W-1:0]] <= in_word.char_code;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/code_lock_with_lockout.sv */
// Top level of the code lock: handshakes, configuration port, output buffer.
// Depends on cll_pkg and cll_core.
// Throughput: one word per cycle while the skid entry is empty; the two-entry
// output buffer keeps input open while one result waits. Reset (rst,
// synchronous): lock locked, entry and counters cleared, time zero,
// configuration back to its defaults.
`timescale 1ns / 1ps
`default_nettype none

module code_lock_with_lockout (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cll_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cll_pkg::out_word_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cll_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]               cfg_data
);
  import cll_pkg::*;

  logic       push, pop;
  out_word_t  result;
  out_word_t  skid_data;
  logic       skid_valid;
  cfg_write_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.we    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  cll_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (push),
    .in_word(in_data),
    .cfg_wr (cfg_wr),
    .result (result)
  );

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= result;
        out_valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cll_checker.sv */
// Port-level checks for the code lock, bound to the top level.
// Depends on cll_pkg and code_lock_with_lockout.
`timescale 1ns / 1ps
`default_nettype none

module cll_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input cll_pkg::out_word_t        out_data
);
  import cll_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Input closes only while a result is waiting
  a_ready_backs: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && $past(out_valid))
    else $error("input stalled with no result waiting");

  // Lamp follows the mode when not blocked
  a_lamp_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.mode != MODE_BLOCKED) |->
      (out_data.lamp == (out_data.mode == MODE_OPEN)))
    else $error("lamp disagrees with mode");

  // Granted opens, lockout blocks with no attempts left
  a_grant_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_res == EV_GRANTED) |-> out_data.mode == MODE_OPEN)
    else $error("granted without open mode");

  a_lockout: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_res == EV_LOCKOUT) |->
      (out_data.mode == MODE_BLOCKED) && (out_data.attempts_left == 4'd0))
    else $error("lockout without blocked mode");

endmodule

bind code_lock_with_lockout cll_checker u_cll_checker (.*);

`default_nettype wire
